>>> rtl/bmp_stream_pixel_reader_assert.svh
// Assertion macros for the BMP stream pixel reader.
// Included by the top level; checks compile out under SYNTHESIS.
`ifndef BMP_STREAM_PIXEL_READER_ASSERT_SVH
`define BMP_STREAM_PIXEL_READER_ASSERT_SVH
`ifndef SYNTHESIS
`define BSR_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("bsr assertion failed");
`define BSR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsr assertion failed");
`else
`define BSR_ASSERT_ALWAYS(label, clk, rst, expr)
`define BSR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/bsr_pkg.sv
// Shared types and constants for the BMP stream pixel reader.
// No dependencies.
package bsr_pkg;

   localparam int DIM_BITS_DEFAULT = 12;

   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PAD_ADDR = 2'd0;

   localparam logic [7:0] MAGIC_B  = 8'h42;
   localparam logic [7:0] MAGIC_M  = 8'h4D;
   localparam logic [15:0] DEPTH_RGB24 = 16'd24;

   localparam logic [5:0] OFF_MAGIC_LOW  = 6'd0;
   localparam logic [5:0] OFF_MAGIC_HIGH = 6'd1;
   localparam logic [5:0] OFF_WIDTH_LO   = 6'd18;
   localparam logic [5:0] OFF_WIDTH_HI   = 6'd21;
   localparam logic [5:0] OFF_HEIGHT_LO  = 6'd22;
   localparam logic [5:0] OFF_HEIGHT_HI  = 6'd25;
   localparam logic [5:0] OFF_DEPTH_LO   = 6'd28;
   localparam logic [5:0] OFF_DEPTH_HI   = 6'd29;
   localparam logic [5:0] OFF_HEADER_END = 6'd53;

   typedef enum logic [2:0] {
      KIND_PIXEL     = 3'd0,
      KIND_HEADER    = 3'd1,
      KIND_BAD_MAGIC = 3'd2,
      KIND_BAD_DEPTH = 3'd3,
      KIND_TOO_LARGE = 3'd4
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [23:0] address;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [12:0] stored_rows;
      logic [12:0] stored_cols;
      logic        image_last;
   } rsp_type;

endpackage

>>> rtl/bsr_parser.sv
// Header parser and pixel sequencer of the BMP stream pixel reader.
// One request per step; depends on bsr_pkg.
module bsr_parser #(
   parameter int DIM_BITS = bsr_pkg::DIM_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  bsr_pkg::req_type item,
   input  logic             pad_mode,
   output logic             res_valid,
   output bsr_pkg::rsp_type res
);

   localparam int DW = DIM_BITS + 1;
   localparam logic [31:0] DIM_LIMIT = 32'(1) << DIM_BITS;

   typedef enum logic [2:0] {
      PH_WAIT, PH_HEADER, PH_PIXELS, PH_DONE, PH_ERROR
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [5:0]  offset_ff, offset_in;
   logic [7:0]  magic_low_ff, magic_low_in;
   logic [31:0] raw_w_ff, raw_w_in;
   logic [31:0] raw_h_ff, raw_h_in;
   logic [7:0]  depth_low_ff, depth_low_in;
   logic [DW-1:0] store_w_ff, store_w_in;
   logic [DW-1:0] store_h_ff, store_h_in;
   logic [DW-1:0] row_ff, row_in;
   logic [DW-1:0] col_ff, col_in;
   logic [1:0]  triple_ff, triple_in;
   logic [1:0]  pad_left_ff, pad_left_in;
   logic [7:0]  blue_ff, blue_in;
   logic [7:0]  green_ff, green_in;
   logic [23:0] addr_ff, addr_in;
   logic [23:0] row_base_ff, row_base_in;

   phase_type   phase_cur;
   logic [5:0]  off;
   logic [1:0]  lane;
   logic [7:0]  b;
   logic [DW-1:0] col_next;
   logic [DW-1:0] row_next;
   logic [23:0] base_next;
   logic        empty;

   function automatic logic [DW-1:0] round_pow2(input logic [DW-1:0] n);
      logic [DW-1:0] m;
      m = n - DW'(1);
      for (int s = 1; s <= DIM_BITS; s = s * 2) begin
         m = m | (m >> s);
      end
      if (n == '0) begin
         return DW'(1);
      end
      return m + DW'(1);
   endfunction

   always_comb begin
      b         = item.data_byte;
      phase_cur = item.first_byte ? PH_HEADER : phase_ff;
      off       = item.first_byte ? bsr_pkg::OFF_MAGIC_LOW : offset_ff;
      lane      = off[1:0] - 2'd2;
      col_next  = col_ff + DW'(1);
      row_next  = row_ff + DW'(1);
      base_next = row_base_ff + 24'(store_w_ff);
      empty     = 1'b0;

      phase_in     = phase_cur;
      offset_in    = offset_ff;
      magic_low_in = magic_low_ff;
      raw_w_in     = item.first_byte ? '0 : raw_w_ff;
      raw_h_in     = item.first_byte ? '0 : raw_h_ff;
      depth_low_in = item.first_byte ? '0 : depth_low_ff;
      store_w_in   = store_w_ff;
      store_h_in   = store_h_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      triple_in    = triple_ff;
      pad_left_in  = pad_left_ff;
      blue_in      = blue_ff;
      green_in     = green_ff;
      addr_in      = addr_ff;
      row_base_in  = row_base_ff;

      res_valid = 1'b0;
      res       = '0;

      unique case (phase_cur)
         PH_HEADER: begin
            offset_in = off + 6'd1;
            if (off == bsr_pkg::OFF_MAGIC_LOW) begin
               magic_low_in = b;
            end else if (off == bsr_pkg::OFF_MAGIC_HIGH) begin
               if (magic_low_ff != bsr_pkg::MAGIC_B || b != bsr_pkg::MAGIC_M) begin
                  phase_in  = PH_ERROR;
                  res_valid = 1'b1;
                  res.kind  = bsr_pkg::KIND_BAD_MAGIC;
               end
            end else begin
               if (off >= bsr_pkg::OFF_WIDTH_LO && off <= bsr_pkg::OFF_WIDTH_HI) begin
                  raw_w_in[{lane, 3'b000} +: 8] = b;
               end else if (off >= bsr_pkg::OFF_HEIGHT_LO &&
                            off <= bsr_pkg::OFF_HEIGHT_HI) begin
                  raw_h_in[{lane, 3'b000} +: 8] = b;
               end else if (off == bsr_pkg::OFF_DEPTH_LO) begin
                  depth_low_in = b;
               end
               if (off == bsr_pkg::OFF_DEPTH_HI) begin
                  if ({b, depth_low_ff} != bsr_pkg::DEPTH_RGB24) begin
                     phase_in  = PH_ERROR;
                     res_valid = 1'b1;
                     res.kind  = bsr_pkg::KIND_BAD_DEPTH;
                  end else if (raw_w_ff > DIM_LIMIT || raw_h_ff > DIM_LIMIT) begin
                     phase_in  = PH_ERROR;
                     res_valid = 1'b1;
                     res.kind  = bsr_pkg::KIND_TOO_LARGE;
                  end
               end
               if (off == bsr_pkg::OFF_HEADER_END) begin
                  empty       = (raw_w_ff == '0) || (raw_h_ff == '0);
                  store_w_in  = pad_mode ? round_pow2(raw_w_ff[DW-1:0]) : raw_w_ff[DW-1:0];
                  store_h_in  = pad_mode ? round_pow2(raw_h_ff[DW-1:0]) : raw_h_ff[DW-1:0];
                  row_in      = '0;
                  col_in      = '0;
                  triple_in   = 2'd0;
                  pad_left_in = 2'd0;
                  addr_in     = '0;
                  row_base_in = '0;
                  phase_in    = empty ? PH_DONE : PH_PIXELS;
                  res_valid       = 1'b1;
                  res.kind        = bsr_pkg::KIND_HEADER;
                  res.stored_rows = 13'(store_h_in);
                  res.stored_cols = 13'(store_w_in);
                  res.image_last  = empty;
               end
            end
         end
         PH_PIXELS: begin
            if (pad_left_ff != 2'd0) begin
               pad_left_in = pad_left_ff - 2'd1;
            end else if (triple_ff == 2'd0) begin
               blue_in   = b;
               triple_in = 2'd1;
            end else if (triple_ff == 2'd1) begin
               green_in  = b;
               triple_in = 2'd2;
            end else begin
               triple_in       = 2'd0;
               res_valid       = 1'b1;
               res.kind        = bsr_pkg::KIND_PIXEL;
               res.address     = addr_ff;
               res.red         = b;
               res.green       = green_ff;
               res.blue        = blue_ff;
               res.stored_rows = 13'(store_h_ff);
               res.stored_cols = 13'(store_w_ff);
               if (col_next >= raw_w_ff[DW-1:0]) begin
                  col_in      = '0;
                  row_in      = row_next;
                  pad_left_in = raw_w_ff[1:0];
                  row_base_in = base_next;
                  addr_in     = base_next;
                  if (row_next >= raw_h_ff[DW-1:0]) begin
                     res.image_last = 1'b1;
                     phase_in       = PH_DONE;
                  end
               end else begin
                  col_in  = col_next;
                  addr_in = addr_ff + 24'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         offset_ff    <= '0;
         magic_low_ff <= '0;
         raw_w_ff     <= '0;
         raw_h_ff     <= '0;
         depth_low_ff <= '0;
         store_w_ff   <= '0;
         store_h_ff   <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         triple_ff    <= '0;
         pad_left_ff  <= '0;
         blue_ff      <= '0;
         green_ff     <= '0;
         addr_ff      <= '0;
         row_base_ff  <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         offset_ff    <= offset_in;
         magic_low_ff <= magic_low_in;
         raw_w_ff     <= raw_w_in;
         raw_h_ff     <= raw_h_in;
         depth_low_ff <= depth_low_in;
         store_w_ff   <= store_w_in;
         store_h_ff   <= store_h_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         triple_ff    <= triple_in;
         pad_left_ff  <= pad_left_in;
         blue_ff      <= blue_in;
         green_ff     <= green_in;
         addr_ff      <= addr_in;
         row_base_ff  <= row_base_in;
      end
   end

endmodule

>>> rtl/bmp_stream_pixel_reader.sv
// A request is registered, then its result, if any, is queued and offered on rsp_valid.
// One request per cycle when req_stall is low; a two-entry queue absorbs output stalls.
// req_stall rises only when the input register holds a request and the queue is full.
// Reset (synchronous, active high) clears the parser, queue and mode register.
// Depends on bsr_pkg, bsr_parser and bmp_stream_pixel_reader_assert.svh.
`include "bmp_stream_pixel_reader_assert.svh"
module bmp_stream_pixel_reader #(
   parameter int DIM_BITS = bsr_pkg::DIM_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  bsr_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output bsr_pkg::rsp_type                   rsp_payload,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [bsr_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [bsr_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [bsr_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);

   logic             pad_ff;
   logic             in_valid_ff;
   bsr_pkg::req_type in_item_ff;
   bsr_pkg::rsp_type queue_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             queue_full;
   logic             load;
   logic             move;
   logic             pop;
   logic             res_valid;
   bsr_pkg::rsp_type res;

   assign pready = 1'b1;
   assign prdata = (paddr == bsr_pkg::CSR_PAD_ADDR) ? bsr_pkg::CSR_DATA_BITS'(pad_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready && paddr == bsr_pkg::CSR_PAD_ADDR) begin
         pad_ff <= pwdata[0];
      end
   end

   assign queue_full = (count_ff == 2'd2);
   assign req_stall  = in_valid_ff && queue_full;
   assign load       = req_valid && !req_stall;
   assign move       = in_valid_ff && !queue_full;
   assign pop        = rsp_valid && !rsp_stall;
   assign rsp_valid  = (count_ff != 2'd0);
   assign rsp_payload = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (load) begin
         in_valid_ff <= 1'b1;
      end else if (move) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_item_ff <= req_payload;
      end
   end

   bsr_parser #(
      .DIM_BITS (DIM_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (move),
      .item      (in_item_ff),
      .pad_mode  (pad_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (move && res_valid) begin
         queue_ff[wr_ptr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (move && res_valid) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(move && res_valid) - 2'(pop);
      end
   end

   `BSR_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= 2'd2)
   `BSR_ASSERT_IMPLY(a_push_has_room, clock, reset, move && res_valid, !queue_full)
   `BSR_ASSERT_IMPLY(a_stall_needs_item, clock, reset, req_stall, in_valid_ff && queue_full)

endmodule
